>>> hdl/otun_pkg.sv
package otun_pkg;

  // coordinate, edge, cross product and dot product widths
  localparam int unsigned CW = 32;
  localparam int unsigned EW = CW + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned NW = PW + 1;
  localparam int unsigned DW = 102;
  // normalized magnitude, sum of squares and length widths
  localparam int unsigned AW = 31;
  localparam int unsigned SW = 64;
  localparam int unsigned LW = 32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DEGEN    = 2'd1,
    ST_ON_PLANE = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
    logic signed [CW-1:0] ref_x;
    logic signed [CW-1:0] ref_y;
    logic signed [CW-1:0] ref_z;
  } req_t;

  typedef struct packed {
    logic signed [CW-1:0] normal_x;
    logic signed [CW-1:0] normal_y;
    logic signed [CW-1:0] normal_z;
    logic [1:0]           status;
  } res_t;

  // control that travels with each request down the pipeline
  typedef struct packed {
    logic       vld;
    status_e    status;
    logic [2:0] neg;
  } ctl_t;

endpackage

>>> hdl/otun_cross.sv
module otun_cross (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                vld_i,
  input  otun_pkg::req_t                      req_i,
  output otun_pkg::ctl_t                      ctl_o,
  output logic [2:0][otun_pkg::NW-1:0]        mag_o
);

  localparam int unsigned EW = otun_pkg::EW;
  localparam int unsigned PW = otun_pkg::PW;
  localparam int unsigned NW = otun_pkg::NW;
  localparam int unsigned DW = otun_pkg::DW;
  localparam int unsigned SPLIT = 34;
  localparam int unsigned LOW = SPLIT + 1 + EW;
  localparam int unsigned HIW = (NW - SPLIT) + EW;

  logic [6:1] v_q;

  logic signed [EW-1:0]  e1_q [3];
  logic signed [EW-1:0]  e2_q [3];
  logic signed [EW-1:0]  d1_q [3];
  logic signed [PW-1:0]  p_q  [6];
  logic signed [EW-1:0]  d2_q [3];
  logic signed [NW-1:0]  n3_q [3];
  logic signed [EW-1:0]  d3_q [3];
  logic signed [LOW-1:0] lo_q [3];
  logic signed [HIW-1:0] hi_q [3];
  logic signed [NW-1:0]  n4_q [3];
  logic signed [DW-1:0]  pc_q [3];
  logic [NW-1:0]         mag5_q [3];
  logic [2:0]            sgn5_q;
  logic                  zero5_q;

  logic signed [DW-1:0]  dot_d;
  otun_pkg::ctl_t        ctl_d;
  otun_pkg::ctl_t        ctl_q;
  logic [2:0][NW-1:0]    mag_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[5:1], vld_i};
    end
  end

  // stage 1: edges and offset of the reference point
  always_ff @(posedge clk_i) begin
    e1_q[0] <= $signed({req_i.v1_x[31], req_i.v1_x}) - $signed({req_i.v0_x[31], req_i.v0_x});
    e1_q[1] <= $signed({req_i.v1_y[31], req_i.v1_y}) - $signed({req_i.v0_y[31], req_i.v0_y});
    e1_q[2] <= $signed({req_i.v1_z[31], req_i.v1_z}) - $signed({req_i.v0_z[31], req_i.v0_z});
    e2_q[0] <= $signed({req_i.v2_x[31], req_i.v2_x}) - $signed({req_i.v0_x[31], req_i.v0_x});
    e2_q[1] <= $signed({req_i.v2_y[31], req_i.v2_y}) - $signed({req_i.v0_y[31], req_i.v0_y});
    e2_q[2] <= $signed({req_i.v2_z[31], req_i.v2_z}) - $signed({req_i.v0_z[31], req_i.v0_z});
    d1_q[0] <= $signed({req_i.ref_x[31], req_i.ref_x}) - $signed({req_i.v0_x[31], req_i.v0_x});
    d1_q[1] <= $signed({req_i.ref_y[31], req_i.ref_y}) - $signed({req_i.v0_y[31], req_i.v0_y});
    d1_q[2] <= $signed({req_i.ref_z[31], req_i.ref_z}) - $signed({req_i.v0_z[31], req_i.v0_z});
  end

  // stage 2: the six cross product terms
  always_ff @(posedge clk_i) begin
    p_q[0] <= e1_q[1] * e2_q[2];
    p_q[1] <= e1_q[2] * e2_q[1];
    p_q[2] <= e1_q[2] * e2_q[0];
    p_q[3] <= e1_q[0] * e2_q[2];
    p_q[4] <= e1_q[0] * e2_q[1];
    p_q[5] <= e1_q[1] * e2_q[0];
    d2_q   <= d1_q;
  end

  // stage 3: cross product components
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      n3_q[i] <= NW'(p_q[2*i]) - NW'(p_q[2*i+1]);
    end
    d3_q <= d2_q;
  end

  // stage 4: dot product partial products, normal split at bit SPLIT
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      lo_q[i] <= $signed({1'b0, n3_q[i][SPLIT-1:0]}) * d3_q[i];
      hi_q[i] <= $signed(n3_q[i][NW-1:SPLIT]) * d3_q[i];
    end
    n4_q <= n3_q;
  end

  // stage 5: per-component dot terms, magnitudes and signs
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pc_q[i]   <= (DW'(hi_q[i]) <<< SPLIT) + DW'(lo_q[i]);
      mag5_q[i] <= n4_q[i][NW-1] ? NW'(-n4_q[i]) : NW'(n4_q[i]);
      sgn5_q[i] <= n4_q[i][NW-1];
    end
    zero5_q <= (n4_q[0] == '0) && (n4_q[1] == '0) && (n4_q[2] == '0);
  end

  // stage 6: dot product sum, status and orientation
  always_comb begin
    dot_d      = pc_q[0] + pc_q[1] + pc_q[2];
    ctl_d.vld  = v_q[5];
    ctl_d.neg  = sgn5_q ^ {3{~dot_d[DW-1]}};
    if (zero5_q) begin
      ctl_d.status = otun_pkg::ST_DEGEN;
    end else if (dot_d == '0) begin
      ctl_d.status = otun_pkg::ST_ON_PLANE;
    end else begin
      ctl_d.status = otun_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      mag_q[i] <= mag5_q[i];
    end
  end

  assign ctl_o = '{vld: v_q[6], status: ctl_q.status, neg: ctl_q.neg};
  assign mag_o = mag_q;

endmodule

>>> hdl/otun_norm.sv
module otun_norm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  otun_pkg::ctl_t                ctl_i,
  input  logic [2:0][otun_pkg::NW-1:0]  mag_i,
  output otun_pkg::ctl_t                ctl_o,
  output logic [2:0][otun_pkg::AW-1:0]  a_o,
  output logic [otun_pkg::SW-1:0]       s_o
);

  localparam int unsigned NW = otun_pkg::NW;
  localparam int unsigned AW = otun_pkg::AW;
  localparam int unsigned SW = otun_pkg::SW;

  otun_pkg::ctl_t     ctl_q [4];
  logic [NW-1:0]      o1_d, o1_q, o2_d;
  logic [2:0][NW-1:0] m1_d, m1_q, m2_d;
  logic [2:0][AW-1:0] a2_q, a3_q, a4_q;
  logic [2*AW-1:0]    sq_q [3];
  logic [SW-1:0]      s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) ctl_q[k] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
      for (int k = 1; k < 4; k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  // coarse left-justify of the OR of all magnitudes: 64, 32, 16
  always_comb begin
    o1_d = mag_i[0] | mag_i[1] | mag_i[2];
    m1_d = mag_i;
    if (o1_d[NW-1 -: 64] == '0) begin
      o1_d = o1_d << 64;
      for (int i = 0; i < 3; i++) m1_d[i] = m1_d[i] << 64;
    end
    if (o1_d[NW-1 -: 32] == '0) begin
      o1_d = o1_d << 32;
      for (int i = 0; i < 3; i++) m1_d[i] = m1_d[i] << 32;
    end
    if (o1_d[NW-1 -: 16] == '0) begin
      o1_d = o1_d << 16;
      for (int i = 0; i < 3; i++) m1_d[i] = m1_d[i] << 16;
    end
  end

  always_ff @(posedge clk_i) begin
    o1_q <= o1_d;
    m1_q <= m1_d;
  end

  // fine left-justify: 8, 4, 2, 1
  always_comb begin
    o2_d = o1_q;
    m2_d = m1_q;
    if (o2_d[NW-1 -: 8] == '0) begin
      o2_d = o2_d << 8;
      for (int i = 0; i < 3; i++) m2_d[i] = m2_d[i] << 8;
    end
    if (o2_d[NW-1 -: 4] == '0) begin
      o2_d = o2_d << 4;
      for (int i = 0; i < 3; i++) m2_d[i] = m2_d[i] << 4;
    end
    if (o2_d[NW-1 -: 2] == '0) begin
      o2_d = o2_d << 2;
      for (int i = 0; i < 3; i++) m2_d[i] = m2_d[i] << 2;
    end
    if (!o2_d[NW-1]) begin
      for (int i = 0; i < 3; i++) m2_d[i] = m2_d[i] << 1;
    end
  end

  // top AW bits of the justified word: largest lands in [2^30, 2^31)
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) a2_q[i] <= m2_d[i][NW-1 -: AW];
  end

  // squares, then their sum
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) sq_q[i] <= a2_q[i] * a2_q[i];
    a3_q <= a2_q;
    s_q  <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
    a4_q <= a3_q;
  end

  assign ctl_o = ctl_q[3];
  assign a_o   = a4_q;
  assign s_o   = s_q;

endmodule

>>> hdl/otun_sqrt.sv
module otun_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  otun_pkg::ctl_t                ctl_i,
  input  logic [2:0][otun_pkg::AW-1:0]  a_i,
  input  logic [otun_pkg::SW-1:0]       s_i,
  output otun_pkg::ctl_t                ctl_o,
  output logic [2:0][otun_pkg::AW-1:0]  a_o,
  output logic [otun_pkg::LW-1:0]       len_o
);

  localparam int unsigned SW = otun_pkg::SW;
  localparam int unsigned AW = otun_pkg::AW;
  localparam int unsigned LW = otun_pkg::LW;
  localparam int unsigned NSTG = SW / 2;

  otun_pkg::ctl_t     ctl_q [NSTG];
  logic [2:0][AW-1:0] a_q   [NSTG];
  logic [SW-1:0]      x_q   [NSTG];
  logic [SW-1:0]      r_q   [NSTG];

  // one result bit per stage, digit-by-digit square root
  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * k);
    otun_pkg::ctl_t     ctl_in;
    logic [2:0][AW-1:0] a_in;
    logic [SW-1:0]      x_in, r_in, t, x_d, r_d;

    if (k == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign a_in   = a_i;
      assign x_in   = s_i;
      assign r_in   = '0;
    end else begin : g_next
      assign ctl_in = ctl_q[k-1];
      assign a_in   = a_q[k-1];
      assign x_in   = x_q[k-1];
      assign r_in   = r_q[k-1];
    end

    always_comb begin
      t = r_in + BIT;
      if (x_in >= t) begin
        x_d = x_in - t;
        r_d = (r_in >> 1) + BIT;
      end else begin
        x_d = x_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      a_q[k] <= a_in;
      x_q[k] <= x_d;
      r_q[k] <= r_d;
    end
  end

  assign ctl_o = ctl_q[NSTG-1];
  assign a_o   = a_q[NSTG-1];
  assign len_o = r_q[NSTG-1][LW-1:0];

endmodule

>>> hdl/otun_div.sv
module otun_div #(
  parameter int unsigned OUT_FRAC_BITS = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  otun_pkg::ctl_t                ctl_i,
  input  logic [2:0][otun_pkg::AW-1:0]  a_i,
  input  logic [otun_pkg::LW-1:0]       len_i,
  output logic                          vld_o,
  output otun_pkg::res_t                res_o
);

  localparam int unsigned AW = otun_pkg::AW;
  localparam int unsigned LW = otun_pkg::LW;
  localparam int unsigned CW = otun_pkg::CW;
  localparam int unsigned Q = OUT_FRAC_BITS + 1;
  localparam int unsigned NUMW = AW + OUT_FRAC_BITS + 1;
  localparam logic [Q-1:0] LIM = Q'(1) << OUT_FRAC_BITS;

  // pre-stage: rounded numerators and first partial remainders
  otun_pkg::ctl_t       ctl0_q;
  logic [2:0][NUMW-1:0] num0_q;
  logic [2:0][LW-1:0]   rem0_q;
  logic [LW-1:0]        len0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else begin
      ctl0_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      num0_q[i] <= (NUMW'(a_i[i]) << OUT_FRAC_BITS) + NUMW'(len_i >> 1);
      rem0_q[i] <= LW'(((NUMW'(a_i[i]) << OUT_FRAC_BITS) + NUMW'(len_i >> 1)) >> Q);
    end
    len0_q <= len_i;
  end

  // restoring division, one quotient bit per stage, three lanes
  otun_pkg::ctl_t       ctl_q [Q];
  logic [2:0][NUMW-1:0] num_q [Q];
  logic [2:0][LW-1:0]   rem_q [Q];
  logic [2:0][Q-1:0]    quo_q [Q];
  logic [LW-1:0]        len_q [Q];

  for (genvar k = 0; k < Q; k++) begin : g_stg
    otun_pkg::ctl_t       ctl_in;
    logic [2:0][NUMW-1:0] num_in;
    logic [2:0][LW-1:0]   rem_in, rem_d;
    logic [2:0][Q-1:0]    quo_in, quo_d;
    logic [LW-1:0]        len_in;
    logic [LW:0]          trial [3];

    if (k == 0) begin : g_first
      assign ctl_in = ctl0_q;
      assign num_in = num0_q;
      assign rem_in = rem0_q;
      assign quo_in = '0;
      assign len_in = len0_q;
    end else begin : g_next
      assign ctl_in = ctl_q[k-1];
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign len_in = len_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {rem_in[i], num_in[i][Q-1-k]};
        if (trial[i] >= {1'b0, len_in}) begin
          rem_d[i] = LW'(trial[i] - {1'b0, len_in});
          quo_d[i] = {quo_in[i][Q-2:0], 1'b1};
        end else begin
          rem_d[i] = LW'(trial[i]);
          quo_d[i] = {quo_in[i][Q-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k] <= num_in;
      rem_q[k] <= rem_d;
      quo_q[k] <= quo_d;
      len_q[k] <= len_in;
    end
  end

  // clamp, apply orientation, zero on bad status
  otun_pkg::ctl_t        ctl_l;
  logic [2:0][Q-1:0]     mag_l;
  logic [2:0][CW-1:0]    nrm_d;
  otun_pkg::res_t        res_d, res_q;
  logic                  vld_q;

  assign ctl_l = ctl_q[Q-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_l[i] = (quo_q[Q-1][i] > LIM) ? LIM : quo_q[Q-1][i];
      if (ctl_l.status != otun_pkg::ST_OK) begin
        nrm_d[i] = '0;
      end else if (ctl_l.neg[i]) begin
        nrm_d[i] = -CW'(mag_l[i]);
      end else begin
        nrm_d[i] = CW'(mag_l[i]);
      end
    end
    res_d.normal_x = nrm_d[0];
    res_d.normal_y = nrm_d[1];
    res_d.normal_z = nrm_d[2];
    res_d.status   = ctl_l.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctl_l.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign vld_o = vld_q;
  assign res_o = res_q;

endmodule

>>> hdl/oriented_triangle_unit_normal_top.sv
// Oriented triangle unit normal. A request carries three vertices and a reference
// point; the unit normal of (v1-v0) x (v2-v0), pointed away from the reference
// point, comes back with a status (ok, degenerate triangle, reference point on
// the plane; both error cases return a zero normal). The unit is fully pipelined:
// busy is always low, a new request is taken every cycle, and each result appears
// on res_o with valid_o high for exactly one cycle. The pipeline holds the 32-stage
// square root and the one-bit-per-stage divider, whose depth follows OUT_FRAC_BITS.
// Results leave in request order and must be captured when valid_o is high; there
// is no way to hold them off.
module oriented_triangle_unit_normal_top #(
  parameter int unsigned OUT_FRAC_BITS = 30
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  otun_pkg::req_t req_i,
  output logic           valid_o,
  output otun_pkg::res_t res_o
);

  otun_pkg::ctl_t                cr_ctl, nm_ctl, sq_ctl;
  logic [2:0][otun_pkg::NW-1:0]  cr_mag;
  logic [2:0][otun_pkg::AW-1:0]  nm_a, sq_a;
  logic [otun_pkg::SW-1:0]       nm_s;
  logic [otun_pkg::LW-1:0]       sq_len;

  // never stalls
  assign busy = 1'b0;

  // edges, cross product, orientation and status
  otun_cross u_cross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start & ~busy),
    .req_i  (req_i),
    .ctl_o  (cr_ctl),
    .mag_o  (cr_mag)
  );

  // common normalizing shift and sum of squares
  otun_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cr_ctl),
    .mag_i  (cr_mag),
    .ctl_o  (nm_ctl),
    .a_o    (nm_a),
    .s_o    (nm_s)
  );

  // vector length
  otun_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (nm_ctl),
    .a_i    (nm_a),
    .s_i    (nm_s),
    .ctl_o  (sq_ctl),
    .a_o    (sq_a),
    .len_o  (sq_len)
  );

  // per-component divide by length, clamp and sign
  otun_div #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sq_ctl),
    .a_i    (sq_a),
    .len_i  (sq_len),
    .vld_o  (valid_o),
    .res_o  (res_o)
  );

`ifndef ASSERT_OFF
  localparam logic signed [31:0] LIM_S = 32'sd1 <<< OUT_FRAC_BITS;

  // normalization puts the largest magnitude in [2^30, 2^31)
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nm_ctl.vld && nm_ctl.status == otun_pkg::ST_OK |-> (nm_a[0] | nm_a[1] | nm_a[2]) >> 30 == 1)
    else $error("normalized magnitude out of range");

  // length of a normalized vector is at least 2^30
  a_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_ctl.vld && sq_ctl.status == otun_pkg::ST_OK |-> sq_len[31:30] != 2'b00)
    else $error("vector length too small");

  // error results carry a zero normal
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.status != otun_pkg::ST_OK |->
      res_o.normal_x == 0 && res_o.normal_y == 0 && res_o.normal_z == 0)
    else $error("nonzero normal on error status");

  // status code is one of the defined ones
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> res_o.status == otun_pkg::ST_OK || res_o.status == otun_pkg::ST_DEGEN ||
      res_o.status == otun_pkg::ST_ON_PLANE)
    else $error("undefined status");

  // components stay within unit magnitude
  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> res_o.normal_x <= LIM_S && res_o.normal_x >= -LIM_S &&
      res_o.normal_y <= LIM_S && res_o.normal_y >= -LIM_S &&
      res_o.normal_z <= LIM_S && res_o.normal_z >= -LIM_S)
    else $error("normal component exceeds unit");
`endif

endmodule
